// File: rtl/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg: shared types, constants and calendar tables
// Field widths, the sequencer state encoding and month-length lookups used
// by the day-difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddd_pkg;

  localparam int YEAR_W       = 14;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int DIFF_W       = 23;
  localparam int DOY_W        = 9;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 24;
  localparam int DEF_MAX_YEAR = 9999;
  localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_ADDT = 5'b00100,
    S_SUBF = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } yr_ctl_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
  } yr_stat_t;

  // days in all months before the given one
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m) inside
      MONTH_FEB:                  r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ddd_year_ctr.sv
// ----------------------------------------------------------------------------
// ddd_year_ctr: year counter with leap tracking
// Counts years up from 1 and keeps running residues modulo 4, 100 and 400 so
// the leap flag of the current year comes without any division.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_year_ctr (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire ddd_pkg::yr_ctl_t  ctl_i,
  output ddd_pkg::yr_stat_t      stat_o
);

  logic [ddd_pkg::YEAR_W-1:0] year_q;
  logic [1:0]                 c4_q;
  logic [6:0]                 c100_q;
  logic [8:0]                 c400_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= '0;
      c4_q   <= '0;
      c100_q <= '0;
      c400_q <= '0;
    end else if (ctl_i.clear) begin
      year_q <= ddd_pkg::YEAR_W'(1);
      c4_q   <= 2'd1;
      c100_q <= 7'd1;
      c400_q <= 9'd1;
    end else if (ctl_i.step) begin
      year_q <= year_q + ddd_pkg::YEAR_W'(1);
      c4_q   <= c4_q + 2'd1;
      c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
      c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
    end
  end

  assign stat_o.year = year_q;
  assign stat_o.leap = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);

endmodule

`default_nettype wire

// File: rtl/date_day_difference.sv
// ----------------------------------------------------------------------------
// date_day_difference: signed day count between two Gregorian dates
// Walks the years from 1 up to the later of the two years, adding or
// subtracting the length of each year lying between the two years in one
// shared accumulator, then applies the day-of-year of both dates.
// Sequence: the year walk (S_WALK), then S_ADDT and S_SUBF, then S_DONE;
//   a year or month out of range goes from S_IDLE straight to S_DONE.
// Throughput: a new date pair is taken only in S_IDLE, once the last result
//   has left S_DONE; the year walk through the shared adder steps one year per cycle.
// Reset: rst_ni clears the sequencer and the output valid; no data is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module date_day_difference #(
  parameter int MAX_YEAR = ddd_pkg::DEF_MAX_YEAR
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // from_year[13:0], from_month[17:14], from_day[22:18],
  // to_year[36:23], to_month[40:37], to_day[45:41], zero fill [47:46]
  input  wire  [ddd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // day_difference[22:0], zero fill [23]
  output logic [ddd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // invalid_date[0]
  output logic                              m_axis_tuser
);

  localparam int EffMax = (MAX_YEAR < ddd_pkg::YEAR_FIELD_MAX) ?
                          MAX_YEAR : ddd_pkg::YEAR_FIELD_MAX;
  localparam int AccW   = $clog2(EffMax * 366 + 367) + 1;

  localparam int YW = ddd_pkg::YEAR_W;
  localparam int MW = ddd_pkg::MONTH_W;
  localparam int DW = ddd_pkg::DAY_W;

  ddd_pkg::state_e state_q, state_d;

  logic [YW-1:0] fy_q, ty_q, ymax_q;
  logic [MW-1:0] fm_q, tm_q;
  logic [DW-1:0] fd_q, td_q;
  logic          lf_q, lt_q, inv_q;
  logic signed [AccW-1:0] acc_q, acc_d, operand_s;

  logic [ddd_pkg::DIFF_W-1:0] out_diff_q, sat_diff;
  logic                       out_inv_q, out_valid_q;

  logic [YW-1:0] in_fy, in_ty;
  logic [MW-1:0] in_fm, in_tm;
  logic          in_accept, in_bad, out_load;

  ddd_pkg::yr_ctl_t  yr_ctl;
  ddd_pkg::yr_stat_t yr_stat;

  logic [ddd_pkg::DOY_W-1:0] year_len, doy_t, doy_f;
  logic                      day_t_ok, day_f_ok;

  assign in_fy = s_axis_tdata[13:0];
  assign in_fm = s_axis_tdata[17:14];
  assign in_ty = s_axis_tdata[36:23];
  assign in_tm = s_axis_tdata[40:37];

  assign s_axis_tready = (state_q == ddd_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // year and month range can be checked up front; day needs the leap flag
  assign in_bad = (in_fy == '0) || ({18'd0, in_fy} > 32'(MAX_YEAR)) ||
                  (in_ty == '0) || ({18'd0, in_ty} > 32'(MAX_YEAR)) ||
                  (in_fm < ddd_pkg::MONTH_JAN) || (in_fm > ddd_pkg::MONTH_DEC) ||
                  (in_tm < ddd_pkg::MONTH_JAN) || (in_tm > ddd_pkg::MONTH_DEC);

  ddd_year_ctr u_year_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (yr_ctl),
    .stat_o (yr_stat)
  );

  assign yr_ctl.clear = in_accept;
  assign yr_ctl.step  = (state_q == ddd_pkg::S_WALK) && (yr_stat.year != ymax_q);

  assign year_len = yr_stat.leap ? 9'd366 : 9'd365;

  assign doy_t = ddd_pkg::days_before(tm_q) + ddd_pkg::DOY_W'(td_q) +
                 ddd_pkg::DOY_W'((tm_q > ddd_pkg::MONTH_FEB) && lt_q);
  assign doy_f = ddd_pkg::days_before(fm_q) + ddd_pkg::DOY_W'(fd_q) +
                 ddd_pkg::DOY_W'((fm_q > ddd_pkg::MONTH_FEB) && lf_q);

  assign day_t_ok = (td_q != '0) && (td_q <= ddd_pkg::month_days(tm_q, lt_q));
  assign day_f_ok = (fd_q != '0) && (fd_q <= ddd_pkg::month_days(fm_q, lf_q));

  // operand select for the shared accumulator adder
  always_comb begin
    operand_s = '0;
    case (state_q)
      ddd_pkg::S_WALK: begin
        if ((yr_stat.year < ty_q) && !(yr_stat.year < fy_q)) begin
          operand_s = signed'(AccW'(year_len));
        end else if ((yr_stat.year < fy_q) && !(yr_stat.year < ty_q)) begin
          operand_s = -signed'(AccW'(year_len));
        end
      end
      ddd_pkg::S_ADDT: operand_s = signed'(AccW'(doy_t));
      ddd_pkg::S_SUBF: operand_s = -signed'(AccW'(doy_f));
      default:         operand_s = '0;
    endcase
  end

  assign acc_d = acc_q + operand_s;

  assign out_load = (state_q == ddd_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddd_pkg::S_IDLE: if (in_accept) state_d = in_bad ? ddd_pkg::S_DONE : ddd_pkg::S_WALK;
      ddd_pkg::S_WALK: if (yr_stat.year == ymax_q) state_d = ddd_pkg::S_ADDT;
      ddd_pkg::S_ADDT: state_d = ddd_pkg::S_SUBF;
      ddd_pkg::S_SUBF: state_d = ddd_pkg::S_DONE;
      ddd_pkg::S_DONE: if (out_load) state_d = ddd_pkg::S_IDLE;
      default:         state_d = ddd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fy_q   <= in_fy;
      fm_q   <= in_fm;
      fd_q   <= s_axis_tdata[22:18];
      ty_q   <= in_ty;
      tm_q   <= in_tm;
      td_q   <= s_axis_tdata[45:41];
      ymax_q <= (in_fy > in_ty) ? in_fy : in_ty;
      inv_q  <= in_bad;
      acc_q  <= '0;
      lf_q   <= 1'b0;
      lt_q   <= 1'b0;
    end else begin
      case (state_q)
        ddd_pkg::S_WALK: begin
          acc_q <= acc_d;
          // capture the leap flag as the walk passes each date's year
          if (yr_stat.year == fy_q) lf_q <= yr_stat.leap;
          if (yr_stat.year == ty_q) lt_q <= yr_stat.leap;
        end
        ddd_pkg::S_ADDT: begin
          acc_q <= acc_d;
          if (!day_t_ok) inv_q <= 1'b1;
        end
        ddd_pkg::S_SUBF: begin
          acc_q <= acc_d;
          if (!day_f_ok) inv_q <= 1'b1;
        end
        default: acc_q <= acc_q;
      endcase
    end
    if (out_load) begin
      out_diff_q <= inv_q ? '0 : sat_diff;
      out_inv_q  <= inv_q;
    end
  end

  generate
    if (AccW > ddd_pkg::DIFF_W) begin : g_sat
      logic sat_hi, sat_lo;
      assign sat_hi = !acc_q[AccW-1] && (|acc_q[AccW-2:ddd_pkg::DIFF_W-1]);
      assign sat_lo = acc_q[AccW-1] && !(&acc_q[AccW-2:ddd_pkg::DIFF_W-1]);
      assign sat_diff = sat_hi ? {1'b0, {(ddd_pkg::DIFF_W-1){1'b1}}} :
                        sat_lo ? {1'b1, {(ddd_pkg::DIFF_W-1){1'b0}}} :
                                 acc_q[ddd_pkg::DIFF_W-1:0];
    end else begin : g_ext
      assign sat_diff = ddd_pkg::DIFF_W'(acc_q);
    end
  endgenerate

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_diff_q};
  assign m_axis_tuser  = out_inv_q;

  // the walk never passes the later year
  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ddd_pkg::S_WALK) |-> (yr_stat.year <= ymax_q))
    else $error("year walk ran past the later year");

  // residue counters stay aligned with the year count
  a_leap_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ddd_pkg::S_WALK) && (yr_stat.year[1:0] != 2'b00)) |-> !yr_stat.leap)
    else $error("leap flag set on a year not divisible by four");

  // an invalid date always reports a zero difference
  a_inv_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid date with nonzero difference");

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for date_day_difference
// Streams date pairs into the block and checks every signed day count and
// invalid flag against an independent calendar computation. Each item is
// queued at its input transfer and matched in order at its output transfer.
// The run covers a directed list of calendar corners, then random pairs in
// phases with no idling, an idle sender, a stalling receiver and both.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ddd_pkg::YEAR_W-1:0]  from_year;
    logic [ddd_pkg::MONTH_W-1:0] from_month;
    logic [ddd_pkg::DAY_W-1:0]   from_day;
    logic [ddd_pkg::YEAR_W-1:0]  to_year;
    logic [ddd_pkg::MONTH_W-1:0] to_month;
    logic [ddd_pkg::DAY_W-1:0]   to_day;
  } date_pair_t;

  typedef struct packed {
    logic [ddd_pkg::DIFF_W-1:0] day_difference;
    logic                       invalid_date;
  } day_result_t;

  localparam int RANDOM_PER_PHASE = 19;
  localparam int SMALL_YEAR_MAX   = 400;

  // --------------------------------------------------------------------------
  // Calendar arithmetic and result queue
  // --------------------------------------------------------------------------
  class day_diff_scoreboard;
    day_result_t pending_results[$];
    int          mismatch_cnt = 0;

    static function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned common_month_len(int unsigned m);
      case (m)
        2:            return 28;
        4, 6, 9, 11:  return 30;
        default:      return 31;
      endcase
    endfunction

    static function int unsigned days_in_month(int unsigned y, int unsigned m);
      if (m == 2 && is_leap(y)) return 29;
      return common_month_len(m);
    endfunction

    static function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
      if (y < 1 || y > ddd_pkg::DEF_MAX_YEAR) return 1'b0;
      if (m < 1 || m > 12) return 1'b0;
      return (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // days since the start of year 1, day 1 counting as 1
    static function longint absolute_day(int unsigned y, int unsigned m, int unsigned d);
      longint prior;
      longint n;
      prior = longint'(y) - 1;
      n = prior * 365 + prior / 4 - prior / 100 + prior / 400;
      for (int unsigned i = 1; i < m; i++) n += common_month_len(i);
      n += d;
      if (m > 2 && is_leap(y)) n += 1;
      return n;
    endfunction

    static function day_result_t predict_day_difference(date_pair_t p);
      day_result_t r;
      longint      diff;
      longint      hi;
      r = '0;
      if (!date_valid(p.from_year, p.from_month, p.from_day) ||
          !date_valid(p.to_year, p.to_month, p.to_day)) begin
        r.invalid_date = 1'b1;
        return r;
      end
      diff = absolute_day(p.to_year, p.to_month, p.to_day) -
             absolute_day(p.from_year, p.from_month, p.from_day);
      hi = (longint'(1) << (ddd_pkg::DIFF_W - 1)) - 1;
      if (diff > hi) diff = hi;
      if (diff < -hi - 1) diff = -hi - 1;
      r.day_difference = diff[ddd_pkg::DIFF_W-1:0];
      return r;
    endfunction

    function void note_dates(date_pair_t p);
      pending_results.push_back(predict_day_difference(p));
    endfunction

    function void check_result(logic [ddd_pkg::DIFF_W-1:0] diff, logic invalid);
      day_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected result diff=%0d invalid=%0b", $signed(diff), invalid);
        return;
      end
      exp_r = pending_results.pop_front();
      if (exp_r.day_difference !== diff || exp_r.invalid_date !== invalid) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: expected diff=%0d invalid=%0b, got diff=%0d invalid=%0b",
                   $signed(exp_r.day_difference), exp_r.invalid_date,
                   $signed(diff), invalid);
      end
    endfunction

    function bit drained();
      return pending_results.size() == 0;
    endfunction

    function bit failed();
      return (mismatch_cnt != 0) || (pending_results.size() != 0);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  wire                            s_axis_tready;
  logic [ddd_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  wire                            m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  wire  [ddd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  wire                            m_axis_tuser;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  day_diff_scoreboard sb = new();

  date_day_difference #(
    .MAX_YEAR(ddd_pkg::DEF_MAX_YEAR)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: check each output transfer, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[ddd_pkg::DIFF_W-1:0], m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic date_pair_t mk_pair(int fy, int fm, int fd, int ty, int tm, int td);
    date_pair_t p;
    p.from_year  = fy[ddd_pkg::YEAR_W-1:0];
    p.from_month = fm[ddd_pkg::MONTH_W-1:0];
    p.from_day   = fd[ddd_pkg::DAY_W-1:0];
    p.to_year    = ty[ddd_pkg::YEAR_W-1:0];
    p.to_month   = tm[ddd_pkg::MONTH_W-1:0];
    p.to_day     = td[ddd_pkg::DAY_W-1:0];
    return p;
  endfunction

  function automatic void rand_valid_date(input int unsigned max_y, output int unsigned y,
                                          output int unsigned m, output int unsigned d);
    int unsigned len;
    y = $urandom_range(max_y, 1);
    m = $urandom_range(12, 1);
    len = day_diff_scoreboard::days_in_month(y, m);
    case ($urandom_range(3))
      0:       d = 1;
      1:       d = len;
      default: d = $urandom_range(len, 1);
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    logic [63:0] raw;
    int unsigned fy, fm, fd, ty, tm, td, max_y;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) begin
      // raw noise over the full field widths
      raw = {$urandom, $urandom};
      p = raw[$bits(date_pair_t)-1:0];
      return p;
    end
    max_y = ($urandom_range(9) == 0) ? ddd_pkg::DEF_MAX_YEAR : SMALL_YEAR_MAX;
    rand_valid_date(max_y, fy, fm, fd);
    rand_valid_date(max_y, ty, tm, td);
    if ($urandom_range(3) == 0) begin
      ty = fy;
      td = $urandom_range(day_diff_scoreboard::days_in_month(ty, tm), 1);
    end
    p = mk_pair(fy, fm, fd, ty, tm, td);
    if (r < 24) begin
      // break one field of one date
      case ($urandom_range(3))
        0: p.from_day = ddd_pkg::DAY_W'($urandom_range(
                          31, day_diff_scoreboard::days_in_month(fy, fm) + 1));
        1: p.to_month = ($urandom_range(1) == 0) ? ddd_pkg::MONTH_W'(0) :
                        ddd_pkg::MONTH_W'($urandom_range(15, 13));
        2: p.to_day   = '0;
        default: p.from_year = ($urandom_range(1) == 0) ? ddd_pkg::YEAR_W'(0) :
                               ddd_pkg::YEAR_W'($urandom_range(ddd_pkg::YEAR_FIELD_MAX,
                                                               ddd_pkg::DEF_MAX_YEAR + 1));
      endcase
    end
    return p;
  endfunction

  task automatic send_dates(input date_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p.to_day, p.to_month, p.to_year,
                      p.from_day, p.from_month, p.from_year};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_dates(p);
  endtask

  // hold the input until every queued result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (!sb.drained());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    date_pair_t directed[$];
    int         phase_idle[4];
    int         phase_stall[4];

    phase_idle  = '{0, 84, 0, 12};
    phase_stall = '{0, 0, 84, 12};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(mk_pair(2024, 5, 17, 2024, 5, 17));       // same date
    directed.push_back(mk_pair(1, 1, 1, ddd_pkg::DEF_MAX_YEAR, 12, 31));  // widest forward
    directed.push_back(mk_pair(ddd_pkg::DEF_MAX_YEAR, 12, 31, 1, 1, 1));  // widest backward
    directed.push_back(mk_pair(2023, 3, 1, 2023, 11, 30));       // same year, later target
    directed.push_back(mk_pair(2023, 11, 30, 2023, 3, 1));       // same year, earlier target
    directed.push_back(mk_pair(1999, 12, 31, 2000, 1, 1));
    directed.push_back(mk_pair(2000, 2, 29, 2000, 3, 1));        // leap century
    directed.push_back(mk_pair(2024, 2, 29, 2025, 2, 28));
    directed.push_back(mk_pair(1900, 2, 29, 1900, 3, 1));        // not leap: invalid
    directed.push_back(mk_pair(2023, 1, 1, 2023, 2, 29));        // not leap: invalid
    directed.push_back(mk_pair(2024, 2, 30, 2024, 3, 1));
    directed.push_back(mk_pair(100, 0, 1, 100, 1, 1));           // month zero
    directed.push_back(mk_pair(100, 1, 1, 100, 13, 1));
    directed.push_back(mk_pair(100, 15, 31, 100, 1, 1));         // all-ones month and day
    directed.push_back(mk_pair(100, 1, 0, 100, 1, 1));           // day zero
    directed.push_back(mk_pair(100, 1, 1, 100, 4, 31));          // day past month end
    directed.push_back(mk_pair(0, 1, 1, 10, 1, 1));              // year zero
    directed.push_back(mk_pair(10, 1, 1, ddd_pkg::DEF_MAX_YEAR + 1, 1, 1));
    directed.push_back(mk_pair(ddd_pkg::YEAR_FIELD_MAX, 12, 31, 1, 1, 1));
    directed.push_back(mk_pair(1, 1, 1, 1, 12, 31));
    directed.push_back(mk_pair(400, 12, 31, 401, 1, 1));
    directed.push_back(mk_pair(303, 7, 4, 96, 9, 30));
    directed.push_back(mk_pair(ddd_pkg::DEF_MAX_YEAR, 1, 1, ddd_pkg::DEF_MAX_YEAR, 12, 31));

    foreach (directed[i]) send_dates(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (RANDOM_PER_PHASE) send_dates(random_pair());
    end

    wait_drained();
    // let any stray result surface
    repeat (50) @(posedge clk_i);

    if (sb.failed()) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
